FILE: sv/expression_lexer_top_defines.svh
// assertion macros used by the checker file el_check.sv
`ifndef EXPRESSION_LEXER_TOP_DEFINES_SVH
`define EXPRESSION_LEXER_TOP_DEFINES_SVH

// same-cycle implication, idle during reset
`define EL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("expression lexer check failed");

// next-cycle implication, idle during reset
`define EL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("expression lexer check failed");

`endif

FILE: sv/el_pkg.sv
package el_pkg;

	localparam int POS_BITS = 13;
	localparam int NRES     = 3;

	// result kinds
	localparam logic [1:0] KIND_VAL  = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_CHAR  = 2'd1;
	localparam logic [1:0] ERR_UNTRM = 2'd2;

	// token types
	localparam logic [4:0] TT_NUMBER = 5'd0;
	localparam logic [4:0] TT_IDENT  = 5'd1;
	localparam logic [4:0] TT_STRING = 5'd2;
	localparam logic [4:0] TT_EQEQ   = 5'd3;
	localparam logic [4:0] TT_NEQ    = 5'd4;
	localparam logic [4:0] TT_GEQ    = 5'd5;
	localparam logic [4:0] TT_LEQ    = 5'd6;
	localparam logic [4:0] TT_ANDAND = 5'd7;
	localparam logic [4:0] TT_OROR   = 5'd8;
	localparam logic [4:0] TT_DOT    = 5'd19;
	localparam logic [4:0] TT_END    = 5'd24;
	localparam logic [4:0] TT_NONE   = 5'd0;

	// characters with a role of their own
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	typedef struct packed {
		logic [1:0]          kind;
		logic [4:0]          ttype;
		logic [7:0]          value;
		logic [POS_BITS-1:0] pos;
		logic [1:0]          err;
		logic                last;
	} res_t;

	// all results of one character
	typedef struct packed {
		res_t [NRES-1:0] item;
		logic [1:0]      count;
	} lex_out_t;

	function automatic res_t mk_res(logic [1:0] kind, logic [4:0] ttype, logic [7:0] value,
		logic [POS_BITS-1:0] pos, logic [1:0] err);
		res_t r;
		r.kind  = kind;
		r.ttype = ttype;
		r.value = value;
		r.pos   = pos;
		r.err   = err;
		r.last  = 1'b0;
		return r;
	endfunction

	function automatic logic is_dig(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alp(logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_idc(logic [7:0] c);
		return is_alp(c) || is_dig(c) || (c == CH_UNDER);
	endfunction

	function automatic logic is_ws(logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
	endfunction

	function automatic logic [4:0] single_type(logic [7:0] c);
		logic [4:0] t;
		unique case (c)
			8'h2B: t = 5'd9;   // +
			8'h2D: t = 5'd10;  // -
			8'h2A: t = 5'd11;  // *
			8'h2F: t = 5'd12;  // /
			8'h25: t = 5'd13;  // %
			8'h3E: t = 5'd14;  // >
			8'h3C: t = 5'd15;  // <
			8'h21: t = 5'd16;  // !
			8'h28: t = 5'd17;  // (
			8'h29: t = 5'd18;  // )
			8'h2E: t = TT_DOT; // .
			8'h7C: t = 5'd20;  // |
			8'h3A: t = 5'd21;  // :
			8'h2C: t = 5'd22;  // ,
			8'h3F: t = 5'd23;  // ?
			default: t = TT_NONE;
		endcase
		return t;
	endfunction

	// second character of a two-character operator, zero if none
	function automatic logic [7:0] pair_second(logic [7:0] c);
		logic [7:0] s;
		unique case (c)
			CH_EQ, 8'h21, 8'h3E, 8'h3C: s = CH_EQ;
			CH_AMP:                     s = CH_AMP;
			CH_PIPE:                    s = CH_PIPE;
			default:                    s = CH_NUL;
		endcase
		return s;
	endfunction

	function automatic logic [4:0] pair_type(logic [7:0] c);
		logic [4:0] t;
		unique case (c)
			CH_EQ:   t = TT_EQEQ;
			8'h21:   t = TT_NEQ;
			8'h3E:   t = TT_GEQ;
			8'h3C:   t = TT_LEQ;
			CH_AMP:  t = TT_ANDAND;
			default: t = TT_OROR;
		endcase
		return t;
	endfunction

	function automatic logic [7:0] decode_escape(logic [7:0] c);
		logic [7:0] d;
		unique case (c)
			8'h6E:   d = 8'h0A; // n
			8'h74:   d = 8'h09; // t
			8'h72:   d = 8'h0D; // r
			default: d = c;
		endcase
		return d;
	endfunction

endpackage

FILE: sv/el_lex.sv
module el_lex
	import el_pkg::*;
#(
	parameter int MAX_EXPR_LEN = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] in_char,
	input  logic       in_end,
	output lex_out_t   lex_out
);

	localparam int POS_W = $clog2(MAX_EXPR_LEN + 1);
	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_EXPR_LEN);

	typedef enum logic [3:0] {
		M_IDLE, M_INT, M_NUMDOT, M_FRAC, M_DOTSTRT,
		M_IDENT, M_STR, M_STRESC, M_OPPEND, M_ERROR
	} mode_t;

	mode_t               mode_q, nx_mode;
	logic [7:0]          pend_q, nx_pend;
	logic                qdbl_q, nx_qdbl;
	logic [POS_BITS-1:0] tstart_q, nx_tstart;
	logic [POS_W-1:0]    cpos_q, nx_cpos;

	res_t [NRES-1:0]     res;
	logic [1:0]          n;
	logic                restart;
	logic                ok;
	logic [7:0]          quote;
	logic [POS_BITS-1:0] p13;
	logic [POS_BITS-1:0] prev13;
	logic [4:0]          st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pend_q   <= '0;
			qdbl_q   <= 1'b0;
			tstart_q <= '0;
			cpos_q   <= '0;
		end else if (advance) begin
			mode_q   <= nx_mode;
			pend_q   <= nx_pend;
			qdbl_q   <= nx_qdbl;
			tstart_q <= nx_tstart;
			cpos_q   <= nx_cpos;
		end
	end

	always_comb begin
		nx_mode   = mode_q;
		nx_pend   = pend_q;
		nx_qdbl   = qdbl_q;
		nx_tstart = tstart_q;
		nx_cpos   = cpos_q;
		res       = '0;
		n         = '0;
		restart   = 1'b0;
		ok        = 1'b1;
		quote     = qdbl_q ? CH_DQUOTE : CH_SQUOTE;
		p13       = POS_BITS'(cpos_q);
		prev13    = (cpos_q != '0) ? POS_BITS'(cpos_q - 1'b1) : '0;
		st        = single_type(pend_q);

		if (in_end) begin
			unique case (mode_q)
				M_IDLE: ;
				M_INT, M_FRAC: begin
					res[n] = mk_res(KIND_DONE, TT_NUMBER, 8'h00, tstart_q, ERR_NONE); n = n + 2'd1;
				end
				M_NUMDOT: begin
					res[n] = mk_res(KIND_DONE, TT_NUMBER, 8'h00, tstart_q, ERR_NONE); n = n + 2'd1;
					res[n] = mk_res(KIND_DONE, TT_DOT, 8'h00, prev13, ERR_NONE); n = n + 2'd1;
				end
				M_DOTSTRT: begin
					res[n] = mk_res(KIND_DONE, TT_DOT, 8'h00, tstart_q, ERR_NONE); n = n + 2'd1;
				end
				M_IDENT: begin
					res[n] = mk_res(KIND_DONE, TT_IDENT, 8'h00, tstart_q, ERR_NONE); n = n + 2'd1;
				end
				M_STR: begin
					res[n] = mk_res(KIND_ERR, TT_NONE, 8'h00, p13, ERR_UNTRM); n = n + 2'd1;
					ok = 1'b0;
				end
				M_STRESC: begin
					res[n] = mk_res(KIND_VAL, TT_STRING, CH_BSLASH, tstart_q, ERR_NONE); n = n + 2'd1;
					res[n] = mk_res(KIND_ERR, TT_NONE, 8'h00, p13, ERR_UNTRM); n = n + 2'd1;
					ok = 1'b0;
				end
				M_OPPEND: begin
					if (st == TT_NONE) begin
						res[n] = mk_res(KIND_ERR, TT_NONE, 8'h00, tstart_q, ERR_CHAR); n = n + 2'd1;
						ok = 1'b0;
					end else begin
						res[n] = mk_res(KIND_DONE, st, 8'h00, tstart_q, ERR_NONE); n = n + 2'd1;
					end
				end
				default: ok = 1'b0;
			endcase
			if (ok) begin
				res[n] = mk_res(KIND_DONE, TT_END, 8'h00, p13, ERR_NONE); n = n + 2'd1;
			end
			// end of expression clears everything
			nx_mode   = M_IDLE;
			nx_pend   = '0;
			nx_qdbl   = 1'b0;
			nx_tstart = '0;
			nx_cpos   = '0;
		end else begin
			unique case (mode_q)
				M_IDLE: restart = 1'b1;
				M_INT: begin
					if (is_dig(in_char)) begin
						res[n] = mk_res(KIND_VAL, TT_NUMBER, in_char, tstart_q, ERR_NONE); n = n + 2'd1;
					end else if (in_char == CH_DOT) begin
						nx_mode = M_NUMDOT;
					end else begin
						res[n] = mk_res(KIND_DONE, TT_NUMBER, 8'h00, tstart_q, ERR_NONE); n = n + 2'd1;
						restart = 1'b1;
					end
				end
				M_NUMDOT: begin
					if (is_dig(in_char)) begin
						res[n] = mk_res(KIND_VAL, TT_NUMBER, CH_DOT, tstart_q, ERR_NONE); n = n + 2'd1;
						res[n] = mk_res(KIND_VAL, TT_NUMBER, in_char, tstart_q, ERR_NONE); n = n + 2'd1;
						nx_mode = M_FRAC;
					end else begin
						res[n] = mk_res(KIND_DONE, TT_NUMBER, 8'h00, tstart_q, ERR_NONE); n = n + 2'd1;
						res[n] = mk_res(KIND_DONE, TT_DOT, 8'h00, prev13, ERR_NONE); n = n + 2'd1;
						restart = 1'b1;
					end
				end
				M_FRAC: begin
					if (is_dig(in_char)) begin
						res[n] = mk_res(KIND_VAL, TT_NUMBER, in_char, tstart_q, ERR_NONE); n = n + 2'd1;
					end else begin
						res[n] = mk_res(KIND_DONE, TT_NUMBER, 8'h00, tstart_q, ERR_NONE); n = n + 2'd1;
						restart = 1'b1;
					end
				end
				M_DOTSTRT: begin
					if (is_dig(in_char)) begin
						res[n] = mk_res(KIND_VAL, TT_NUMBER, CH_DOT, tstart_q, ERR_NONE); n = n + 2'd1;
						res[n] = mk_res(KIND_VAL, TT_NUMBER, in_char, tstart_q, ERR_NONE); n = n + 2'd1;
						nx_mode = M_FRAC;
					end else begin
						res[n] = mk_res(KIND_DONE, TT_DOT, 8'h00, tstart_q, ERR_NONE); n = n + 2'd1;
						restart = 1'b1;
					end
				end
				M_IDENT: begin
					if (is_idc(in_char)) begin
						res[n] = mk_res(KIND_VAL, TT_IDENT, in_char, tstart_q, ERR_NONE); n = n + 2'd1;
					end else begin
						res[n] = mk_res(KIND_DONE, TT_IDENT, 8'h00, tstart_q, ERR_NONE); n = n + 2'd1;
						restart = 1'b1;
					end
				end
				M_STR: begin
					if (in_char == CH_NUL) begin
						res[n] = mk_res(KIND_ERR, TT_NONE, 8'h00, p13, ERR_UNTRM); n = n + 2'd1;
						nx_mode = M_ERROR;
					end else if (in_char == quote) begin
						res[n] = mk_res(KIND_DONE, TT_STRING, 8'h00, tstart_q, ERR_NONE); n = n + 2'd1;
						nx_mode = M_IDLE;
					end else if (in_char == CH_BSLASH) begin
						nx_mode = M_STRESC;
					end else begin
						res[n] = mk_res(KIND_VAL, TT_STRING, in_char, tstart_q, ERR_NONE); n = n + 2'd1;
					end
				end
				M_STRESC: begin
					if (in_char == CH_NUL) begin
						res[n] = mk_res(KIND_VAL, TT_STRING, CH_BSLASH, tstart_q, ERR_NONE); n = n + 2'd1;
						res[n] = mk_res(KIND_ERR, TT_NONE, 8'h00, p13, ERR_UNTRM); n = n + 2'd1;
						nx_mode = M_ERROR;
					end else begin
						res[n] = mk_res(KIND_VAL, TT_STRING, decode_escape(in_char), tstart_q,
							ERR_NONE);
						n = n + 2'd1;
						nx_mode = M_STR;
					end
				end
				M_OPPEND: begin
					if (in_char == pair_second(pend_q)) begin
						res[n] = mk_res(KIND_DONE, pair_type(pend_q), 8'h00, tstart_q, ERR_NONE);
						n = n + 2'd1;
						nx_mode = M_IDLE;
					end else if (st == TT_NONE) begin
						// lone '=' or '&'
						res[n] = mk_res(KIND_ERR, TT_NONE, 8'h00, tstart_q, ERR_CHAR); n = n + 2'd1;
						nx_mode = M_ERROR;
					end else begin
						res[n] = mk_res(KIND_DONE, st, 8'h00, tstart_q, ERR_NONE); n = n + 2'd1;
						restart = 1'b1;
					end
				end
				default: ;
			endcase

			// first character of a new token
			if (restart) begin
				nx_mode = M_IDLE;
				if (!is_ws(in_char)) begin
					nx_tstart = p13;
					if (is_dig(in_char)) begin
						res[n] = mk_res(KIND_VAL, TT_NUMBER, in_char, p13, ERR_NONE); n = n + 2'd1;
						nx_mode = M_INT;
					end else if (in_char == CH_DOT) begin
						nx_mode = M_DOTSTRT;
					end else if (is_alp(in_char) || (in_char == CH_UNDER)) begin
						res[n] = mk_res(KIND_VAL, TT_IDENT, in_char, p13, ERR_NONE); n = n + 2'd1;
						nx_mode = M_IDENT;
					end else if ((in_char == CH_DQUOTE) || (in_char == CH_SQUOTE)) begin
						nx_qdbl = (in_char == CH_DQUOTE);
						nx_mode = M_STR;
					end else if (pair_second(in_char) != CH_NUL) begin
						nx_pend = in_char;
						nx_mode = M_OPPEND;
					end else if (single_type(in_char) == TT_NONE) begin
						res[n] = mk_res(KIND_ERR, TT_NONE, 8'h00, p13, ERR_CHAR); n = n + 2'd1;
						nx_mode = M_ERROR;
					end else begin
						res[n] = mk_res(KIND_DONE, single_type(in_char), 8'h00, p13, ERR_NONE);
						n = n + 2'd1;
					end
				end
			end

			// position saturates at the length limit
			if (cpos_q < MAX_POS) begin
				nx_cpos = cpos_q + 1'b1;
			end
		end

		if (n != 2'd0) begin
			res[n - 2'd1].last = 1'b1;
		end
	end

	assign lex_out.item  = res;
	assign lex_out.count = n;

endmodule

FILE: sv/el_obuf.sv
module el_obuf
	import el_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  lex_out_t lex_out,
	input  logic     ready,
	output logic     valid,
	output res_t     head,
	output logic     room
);

	localparam int DEPTH = NRES + 1;

	res_t [DEPTH-1:0] slot_q;
	res_t [DEPTH-1:0] nx_slot;
	logic [2:0]       cnt_q;
	logic [2:0]       base;
	logic [2:0]       k;
	logic             pop;

	assign valid = (cnt_q != 3'd0);
	assign head  = slot_q[0];
	// room for a full set of results whether or not the head leaves
	assign room  = (cnt_q <= 3'd1);
	assign pop   = valid && ready;
	assign base  = cnt_q - {2'b00, pop};

	always_comb begin
		for (int j = 0; j < DEPTH; j++) begin
			if (pop && (j < DEPTH - 1)) begin
				nx_slot[j] = slot_q[j + 1];
			end else begin
				nx_slot[j] = slot_q[j];
			end
			k = 3'(j) - base;
			if (load && (3'(j) >= base) && (k < {1'b0, lex_out.count})) begin
				nx_slot[j] = lex_out.item[k[1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= nx_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= base + (load ? {1'b0, lex_out.count} : 3'd0);
		end
	end

endmodule

FILE: sv/expression_lexer_top.sv
// an input transfer is held in the input stage until the output queue has room;
//   its results are then registered into the queue, whose head drives the output port
// throughput: one input item per cycle while each item yields at most one result and
//   m_tready stays high; an item with more results makes the next wait for queue room
// the four-entry output queue (one result leaves per cycle if ready) sets the sustained rate
// reset: arst_n clears the lexer state, input stage and output queue at once, no sweep
module expression_lexer_top
	import el_pkg::*;
#(
	parameter int MAX_EXPR_LEN = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// input character stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_byte
	input  logic        s_tuser,  // [0] is_end
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [4:0] token_type, [12:5] value_byte,
	                              // [25:13] token position, [27:26] error_code, rest zero
	output logic [1:0]  m_tuser,  // [1:0] out_kind
	output logic        m_tlast   // last result of one input item
);

	// input stage
	logic       v_s1;
	logic [7:0] char_s1;
	logic       end_s1;

	logic       room;
	logic       advance;
	lex_out_t   lex_out;
	res_t       head;

	// the lexer takes the held item only when the queue can absorb all its results;
	// the decision looks at the queue fill alone, so m_tready never reaches s_tready
	assign advance  = v_s1 && room;
	assign s_tready = !v_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	// payload of the input stage, loaded on every input transfer
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			end_s1  <= s_tuser;
		end
	end

	// lexer state and per-character result logic
	el_lex #(
		.MAX_EXPR_LEN(MAX_EXPR_LEN)
	) u_lex (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.in_char (char_s1),
		.in_end  (end_s1),
		.lex_out (lex_out)
	);

	// result queue, head drives the output port
	el_obuf u_obuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance),
		.lex_out (lex_out),
		.ready   (m_tready),
		.valid   (m_tvalid),
		.head    (head),
		.room    (room)
	);

	assign m_tdata = {4'b0000, head.err, head.pos, head.value, head.ttype};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

FILE: sv/el_check.sv
`include "expression_lexer_top_defines.svh"

module el_check
	import el_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled result holds
	`EL_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// an error ends the results of its item and carries no token type
	`EL_ASSERT_IMP(a_err_form, m_tvalid && (m_tuser == KIND_ERR),
		m_tlast && (m_tdata[4:0] == TT_NONE) && (m_tdata[27:26] != ERR_NONE))

	// value byte only on value results, error code only on errors
	`EL_ASSERT_IMP(a_val_zero, m_tvalid && (m_tuser != KIND_VAL), m_tdata[12:5] == 8'h00)
	`EL_ASSERT_IMP(a_code_zero, m_tvalid && (m_tuser != KIND_ERR),
		(m_tdata[27:26] == ERR_NONE) && (m_tuser != 2'd3))

endmodule

bind expression_lexer_top el_check u_el_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

FILE: tb/sv/expression_lexer_top_tb.sv
module expression_lexer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import el_pkg::*;

	// small position ceiling so that long expressions reach saturation quickly
	localparam int unsigned EXPR_LIMIT   = 40;
	localparam int          HALF_PERIOD  = 6;
	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned RANDOM_ITEMS = 360;
	// extra wait that leaves room for stray results after the last one
	localparam int          DRAIN_CYCLES = 16;

	// single-character operator token types
	localparam logic [4:0] TOK_PLUS  = 5'd9;
	localparam logic [4:0] TOK_MINUS = 5'd10;
	localparam logic [4:0] TOK_STAR  = 5'd11;
	localparam logic [4:0] TOK_SLASH = 5'd12;
	localparam logic [4:0] TOK_PCT   = 5'd13;
	localparam logic [4:0] TOK_GT    = 5'd14;
	localparam logic [4:0] TOK_LT    = 5'd15;
	localparam logic [4:0] TOK_BANG  = 5'd16;
	localparam logic [4:0] TOK_LPAR  = 5'd17;
	localparam logic [4:0] TOK_RPAR  = 5'd18;
	localparam logic [4:0] TOK_BAR   = 5'd20;
	localparam logic [4:0] TOK_COLON = 5'd21;
	localparam logic [4:0] TOK_COMMA = 5'd22;
	localparam logic [4:0] TOK_QUEST = 5'd23;

	// blanks
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [3:0] {
		LS_IDLE, LS_INT, LS_NUM_DOT, LS_FRAC, LS_LEAD_DOT,
		LS_IDENT, LS_STR, LS_STR_ESC, LS_OP_HELD, LS_ERROR
	} lex_state_e;

	// predicts the token stream and checks every result transfer against it
	class token_checker;
		int unsigned pos_limit;
		int unsigned fails;
		int unsigned seen_items;  // accepted input items
		res_t        tokens_due[$];
		res_t        batch[$];
		lex_state_e  state;
		logic [7:0]  held_op;
		logic        dquote;
		int unsigned tok_pos;
		int unsigned char_pos;

		function new(int unsigned limit);
			pos_limit  = limit;
			fails      = 0;
			seen_items = 0;
			clear();
		endfunction

		function void clear();
			state    = LS_IDLE;
			held_op  = CH_NUL;
			dquote   = 1'b0;
			tok_pos  = 0;
			char_pos = 0;
		endfunction

		function void add(logic [1:0] kind, logic [4:0] ttype, logic [7:0] value,
			int unsigned pos, logic [1:0] err);
			res_t r;
			if (batch.size() >= 4) return;
			r.kind  = kind;
			r.ttype = ttype;
			r.value = value;
			r.pos   = pos[POS_BITS-1:0];
			r.err   = err;
			r.last  = 1'b0;
			batch.insert(batch.size(), r);
		endfunction

		function void raise_error(int unsigned pos, logic [1:0] code);
			add(KIND_ERR, TT_NONE, CH_NUL, pos, code);
			state = LS_ERROR;
		endfunction

		function bit digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit letter(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		function bit ident_char(logic [7:0] c);
			return letter(c) || digit(c) || c == CH_UNDER;
		endfunction

		function bit blank(logic [7:0] c);
			return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
		endfunction

		function logic [4:0] single_op(logic [7:0] c);
			case (c)
				"+":     return TOK_PLUS;
				"-":     return TOK_MINUS;
				"*":     return TOK_STAR;
				"/":     return TOK_SLASH;
				"%":     return TOK_PCT;
				">":     return TOK_GT;
				"<":     return TOK_LT;
				"!":     return TOK_BANG;
				"(":     return TOK_LPAR;
				")":     return TOK_RPAR;
				".":     return TT_DOT;
				"|":     return TOK_BAR;
				":":     return TOK_COLON;
				",":     return TOK_COMMA;
				"?":     return TOK_QUEST;
				default: return TT_NONE;
			endcase
		endfunction

		// second character that would turn c into a two-character operator
		function logic [7:0] pair_tail(logic [7:0] c);
			case (c)
				CH_EQ, "!", ">", "<": return CH_EQ;
				CH_AMP:               return CH_AMP;
				CH_PIPE:              return CH_PIPE;
				default:              return CH_NUL;
			endcase
		endfunction

		function logic [4:0] pair_op(logic [7:0] c);
			case (c)
				CH_EQ:   return TT_EQEQ;
				"!":     return TT_NEQ;
				">":     return TT_GEQ;
				"<":     return TT_LEQ;
				CH_AMP:  return TT_ANDAND;
				default: return TT_OROR;
			endcase
		endfunction

		function logic [7:0] unescape(logic [7:0] c);
			case (c)
				"n":     return CH_LF;
				"t":     return CH_TAB;
				"r":     return CH_CR;
				default: return c;
			endcase
		endfunction

		// held operator turned out to stand alone; a lone = or & is an error
		function bit resolve_held();
			logic [4:0] t;
			t = single_op(held_op);
			if (t == TT_NONE) begin
				raise_error(tok_pos, ERR_CHAR);
				return 1'b0;
			end
			add(KIND_DONE, t, CH_NUL, tok_pos, ERR_NONE);
			state = LS_IDLE;
			return 1'b1;
		endfunction

		function void begin_token(logic [7:0] c, int unsigned p);
			logic [4:0] t;
			state = LS_IDLE;
			if (blank(c)) return;
			tok_pos = p;
			if (digit(c)) begin
				add(KIND_VAL, TT_NUMBER, c, p, ERR_NONE);
				state = LS_INT;
			end else if (c == CH_DOT) begin
				state = LS_LEAD_DOT;
			end else if (letter(c) || c == CH_UNDER) begin
				add(KIND_VAL, TT_IDENT, c, p, ERR_NONE);
				state = LS_IDENT;
			end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
				dquote = (c == CH_DQUOTE);
				state  = LS_STR;
			end else if (pair_tail(c) != CH_NUL) begin
				held_op = c;
				state   = LS_OP_HELD;
			end else begin
				t = single_op(c);
				if (t == TT_NONE) raise_error(p, ERR_CHAR);
				else add(KIND_DONE, t, CH_NUL, p, ERR_NONE);
			end
		endfunction

		function void take_char(logic [7:0] c, int unsigned p);
			logic [7:0]  quote;
			int unsigned prev;
			quote = dquote ? CH_DQUOTE : CH_SQUOTE;
			prev  = (p > 0) ? p - 1 : 0;
			case (state)
				LS_IDLE: begin
					begin_token(c, p);
				end
				LS_INT: begin
					if (digit(c)) begin
						add(KIND_VAL, TT_NUMBER, c, tok_pos, ERR_NONE);
					end else if (c == CH_DOT) begin
						state = LS_NUM_DOT;
					end else begin
						add(KIND_DONE, TT_NUMBER, CH_NUL, tok_pos, ERR_NONE);
						begin_token(c, p);
					end
				end
				LS_NUM_DOT: begin
					if (digit(c)) begin
						add(KIND_VAL, TT_NUMBER, CH_DOT, tok_pos, ERR_NONE);
						add(KIND_VAL, TT_NUMBER, c, tok_pos, ERR_NONE);
						state = LS_FRAC;
					end else begin
						// the dot becomes an operator, placed just before this character
						add(KIND_DONE, TT_NUMBER, CH_NUL, tok_pos, ERR_NONE);
						add(KIND_DONE, TT_DOT, CH_NUL, prev, ERR_NONE);
						begin_token(c, p);
					end
				end
				LS_FRAC: begin
					if (digit(c)) begin
						add(KIND_VAL, TT_NUMBER, c, tok_pos, ERR_NONE);
					end else begin
						add(KIND_DONE, TT_NUMBER, CH_NUL, tok_pos, ERR_NONE);
						begin_token(c, p);
					end
				end
				LS_LEAD_DOT: begin
					if (digit(c)) begin
						add(KIND_VAL, TT_NUMBER, CH_DOT, tok_pos, ERR_NONE);
						add(KIND_VAL, TT_NUMBER, c, tok_pos, ERR_NONE);
						state = LS_FRAC;
					end else begin
						add(KIND_DONE, TT_DOT, CH_NUL, tok_pos, ERR_NONE);
						begin_token(c, p);
					end
				end
				LS_IDENT: begin
					if (ident_char(c)) begin
						add(KIND_VAL, TT_IDENT, c, tok_pos, ERR_NONE);
					end else begin
						add(KIND_DONE, TT_IDENT, CH_NUL, tok_pos, ERR_NONE);
						begin_token(c, p);
					end
				end
				LS_STR: begin
					if (c == CH_NUL) begin
						raise_error(p, ERR_UNTRM);
					end else if (c == quote) begin
						add(KIND_DONE, TT_STRING, CH_NUL, tok_pos, ERR_NONE);
						state = LS_IDLE;
					end else if (c == CH_BSLASH) begin
						state = LS_STR_ESC;
					end else begin
						add(KIND_VAL, TT_STRING, c, tok_pos, ERR_NONE);
					end
				end
				LS_STR_ESC: begin
					if (c == CH_NUL) begin
						add(KIND_VAL, TT_STRING, CH_BSLASH, tok_pos, ERR_NONE);
						raise_error(p, ERR_UNTRM);
					end else begin
						add(KIND_VAL, TT_STRING, unescape(c), tok_pos, ERR_NONE);
						state = LS_STR;
					end
				end
				LS_OP_HELD: begin
					if (c == pair_tail(held_op)) begin
						add(KIND_DONE, pair_op(held_op), CH_NUL, tok_pos, ERR_NONE);
						state = LS_IDLE;
					end else if (resolve_held()) begin
						begin_token(c, p);
					end
				end
				default: ;
			endcase
		endfunction

		function void take_end(int unsigned p);
			int unsigned prev;
			bit          ok;
			prev = (p > 0) ? p - 1 : 0;
			ok   = 1'b1;
			case (state)
				LS_IDLE: ;
				LS_INT, LS_FRAC: add(KIND_DONE, TT_NUMBER, CH_NUL, tok_pos, ERR_NONE);
				LS_NUM_DOT: begin
					add(KIND_DONE, TT_NUMBER, CH_NUL, tok_pos, ERR_NONE);
					add(KIND_DONE, TT_DOT, CH_NUL, prev, ERR_NONE);
				end
				LS_LEAD_DOT: add(KIND_DONE, TT_DOT, CH_NUL, tok_pos, ERR_NONE);
				LS_IDENT:    add(KIND_DONE, TT_IDENT, CH_NUL, tok_pos, ERR_NONE);
				LS_STR: begin
					raise_error(p, ERR_UNTRM);
					ok = 1'b0;
				end
				LS_STR_ESC: begin
					add(KIND_VAL, TT_STRING, CH_BSLASH, tok_pos, ERR_NONE);
					raise_error(p, ERR_UNTRM);
					ok = 1'b0;
				end
				LS_OP_HELD: ok = resolve_held();
				default:    ok = 1'b0;
			endcase
			if (ok) add(KIND_DONE, TT_END, CH_NUL, p, ERR_NONE);
		endfunction

		// one accepted input transfer
		function void note_input(logic [7:0] c, logic is_end);
			batch.delete();
			seen_items++;
			if (is_end) begin
				take_end(char_pos);
				clear();
			end else begin
				take_char(c, char_pos);
				if (char_pos < pos_limit) char_pos++;
			end
			if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i]) tokens_due.insert(tokens_due.size(), batch[i]);
		endfunction

		function int pending();
			return tokens_due.size();
		endfunction

		function void compare(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				fails++;
			end
		endfunction

		// one accepted result transfer
		function void check_result(res_t got);
			res_t want;
			if (tokens_due.size() == 0) begin
				$error("result with nothing due: kind %0d type %0d pos %0d",
					got.kind, got.ttype, got.pos);
				fails++;
				return;
			end
			want = tokens_due.pop_front();
			compare("out_kind", want.kind, got.kind);
			compare("token_type", want.ttype, got.ttype);
			compare("value_byte", want.value, got.value);
			compare("token position", want.pos, got.pos);
			compare("error_code", want.err, got.err);
			compare("last", want.last, got.last);
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;  // [7:0] char_byte
	logic        s_tuser  = 1'b0;   // [0] is_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // [4:0] token_type, [12:5] value_byte,
	                                // [25:13] token position, [27:26] error_code
	logic [1:0]  m_tuser;           // [1:0] out_kind
	logic        m_tlast;

	token_checker chk;
	int unsigned  cycles     = 0;
	int unsigned  stall_left = 0;
	// per-expression switches that turn idling off for a whole stretch
	bit           tx_steady  = 1'b0;
	bit           rx_steady  = 1'b0;
	logic [7:0]   expr_chars[$];

	expression_lexer_top #(
		.MAX_EXPR_LEN(EXPR_LIMIT)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// idle length: mostly short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	// receiver back-pressure; a stall starts only while ready is high
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (!rx_steady && $urandom_range(0, 99) < 20) stall_left <= pick_gap();
		end
	end

	// both transfers are sampled at the same edge in one process: the input is
	// noted first so its expectations exist before any result is checked
	always @(posedge clk) begin
		res_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) chk.note_input(s_tdata, s_tuser);
			if (m_tvalid && m_tready) begin
				got.kind  = m_tuser;
				got.ttype = m_tdata[4:0];
				got.value = m_tdata[12:5];
				got.pos   = m_tdata[25:13];
				got.err   = m_tdata[27:26];
				got.last  = m_tlast;
				chk.check_result(got);
			end
		end
	end

	// one input transfer, with an optional idle gap in front; valid stays high
	// between back-to-back items so it never sees two assignments in one step
	task automatic send_item(logic [7:0] c, logic is_end);
		int gap;
		gap = (!tx_steady && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tuser  <= is_end;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// end marker, the character byte is don't-care and randomized
	task automatic send_end();
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_str(string s);
		for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
	endtask

	// hold the sender until the result stream has caught up
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (chk.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_ident_head();
		int k;
		k = $urandom_range(0, 52);
		if (k < 26) return 8'("a" + k);
		if (k < 52) return 8'("A" + k - 26);
		return CH_UNDER;
	endfunction

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(0, 3))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			2:       return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	// appends one character to the expression being built
	function automatic void put_char(logic [7:0] c);
		expr_chars.insert(expr_chars.size(), c);
	endfunction

	// appends one mostly well-formed token with random content
	function automatic void add_token();
		string      ops[21] = '{"==", "!=", ">=", "<=", "&&", "||", "+", "-", "*", "/",
			"%", ">", "<", "!", "(", ")", ".", "|", ":", ",", "?"};
		int         pick;
		int         n;
		logic [7:0] q;
		logic [7:0] b;
		string      op;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			// integer, optionally with a dot and zero or more fraction digits
			n = $urandom_range(1, 4);
			repeat (n) put_char(rand_digit());
			if ($urandom_range(0, 99) < 40) begin
				put_char(CH_DOT);
				n = $urandom_range(0, 3);
				repeat (n) put_char(rand_digit());
			end
		end else if (pick < 32) begin
			// leading dot: a number if digits follow, else the dot operator
			put_char(CH_DOT);
			n = $urandom_range(0, 2);
			repeat (n) put_char(rand_digit());
		end else if (pick < 52) begin
			put_char(rand_ident_head());
			n = $urandom_range(0, 5);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0) put_char(rand_digit());
				else put_char(rand_ident_head());
			end
		end else if (pick < 67) begin
			q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
			put_char(q);
			n = $urandom_range(0, 5);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0) begin
					put_char(CH_BSLASH);
					case ($urandom_range(0, 5))
						0:       b = "n";
						1:       b = "t";
						2:       b = "r";
						3:       b = CH_DQUOTE;
						4:       b = CH_SQUOTE;
						default: b = 8'($urandom_range(1, 255));
					endcase
				end else begin
					do b = 8'($urandom_range(1, 255)); while (b == q || b == CH_BSLASH);
				end
				put_char(b);
			end
			// mostly closed; sometimes a zero byte, sometimes left open
			pick = $urandom_range(0, 99);
			if (pick < 90) put_char(q);
			else if (pick < 94) put_char(CH_NUL);
		end else if (pick < 95) begin
			op = ops[$urandom_range(0, 20)];
			for (int i = 0; i < op.len(); i++) put_char(op[i]);
		end else begin
			put_char(8'($urandom_range(0, 255)));
		end
	endfunction

	initial begin
		int n;
		int expr_no;
		chk = new(EXPR_LIMIT);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty expression: only the end token at position zero
		send_end();
		// number followed by a dot at the end: number, then dot just before the end
		send_str("9.");
		send_end();
		// leading-dot fraction, then a held bar resolved by the end marker
		send_str(".5|");
		send_end();
		// lone equals sign is unexpected, what follows it is ignored
		send_str("=x");
		send_end();
		// backslash right before the end: literal backslash, then unterminated
		send_str("'\\");
		send_end();
		// backslash right before a zero byte
		send_str("\"\\");
		send_item(CH_NUL, 1'b0);
		send_end();
		// top byte value and a zero byte outside a string
		send_item(8'hFF, 1'b0);
		send_end();
		send_item(CH_NUL, 1'b0);
		send_end();
		// escape decoding inside a single-quoted string
		send_str("'\\n'");
		send_end();
		wait_drained();

		// random expressions, some long enough to saturate the position counter
		expr_no = 0;
		while (chk.seen_items < RANDOM_ITEMS) begin
			tx_steady = ($urandom_range(0, 4) == 0);
			rx_steady = ($urandom_range(0, 4) == 0);
			expr_chars.delete();
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
			repeat (n) begin
				add_token();
				if ($urandom_range(0, 1) == 0) put_char(rand_blank());
			end
			foreach (expr_chars[i]) send_item(expr_chars[i], 1'b0);
			send_end();
			expr_no++;
			if (expr_no % 8 == 0) wait_drained();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (chk.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (chk.fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
